// ===== sv/msr_pkg.sv =====
package msr_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [7:0]  PWM_PERIOD_RESET    = 8'd100;
   localparam logic [15:0] MEASURE_TICKS_RESET = 16'd10000;
   localparam logic [15:0] ADJUST_TICKS_RESET  = 16'd9999;
   localparam logic [15:0] KEY_TICKS_RESET     = 16'd1500;
   localparam logic [15:0] LED_TICKS_RESET     = 16'd2000;
   localparam logic [15:0] MAX_SPEED_RESET     = 16'd50;
   localparam logic [15:0] MIN_SPEED_RESET     = 16'd20;
   localparam logic [9:0]  START_SPEED_RESET   = 10'd30;
   localparam logic [7:0]  DUTY_RESET          = 8'd50;
   localparam logic [9:0]  TARGET_MAX          = 10'd1023;
   localparam logic [15:0] TICK_MAX            = 16'hFFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PWM_PERIOD      = 3'd0,
      CSR_MEASURE_TICKS   = 3'd1,
      CSR_ADJUST_TICKS    = 3'd2,
      CSR_KEY_TICKS       = 3'd3,
      CSR_LED_TICKS       = 3'd4,
      CSR_MAX_SPEED       = 3'd5,
      CSR_MIN_SPEED       = 3'd6,
      CSR_START_SET_SPEED = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic pulse;
      logic key_down;
      logic key_up;
      logic key_stop;
   } req_word_type;

   typedef struct packed {
      logic        motor_enable;
      logic        alarm_led;
      logic [7:0]  duty_now;
      logic [15:0] speed_measured;
      logic [9:0]  speed_target;
   } rsp_word_type;

   typedef struct packed {
      csr_index_type              index;
      logic [CSR_DATA_WIDTH-1:0]  value;
   } csr_word_type;

   // saturating tick counter step
   function automatic logic [15:0] tick_up(input logic [15:0] c);
      tick_up = (c == TICK_MAX) ? TICK_MAX : c + 16'd1;
   endfunction

endpackage

// ===== sv/msr_if.sv =====
interface msr_req_if;
   import msr_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface msr_rsp_if;
   import msr_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface msr_csr_if;
   import msr_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/motor_speed_pwm_regulator_top.sv =====
// Flow: an accepted word waits in the input register until the skid entry is empty,
//   is then processed, and its result is registered before it shows on rsp_bus.
// Throughput: one word per cycle unless a skid word waits; an input register, the
//   state update and a two-entry output buffer let req_ready stay high while one
//   result waits. Reset (synchronous, active high): registers back to defaults,
//   counters cleared, target 30, duty 50, drive and LED high, pipeline emptied.
module motor_speed_pwm_regulator_top (
   input logic        clock,
   input logic        reset,
   msr_req_if.sink    req_bus,
   msr_rsp_if.source  rsp_bus,
   msr_csr_if.sink    csr_bus
);
   import msr_pkg::*;

   // configuration
   logic [7:0]  pwm_period_ff;
   logic [15:0] measure_ticks_ff, adjust_ticks_ff, key_ticks_ff, led_ticks_ff;
   logic [15:0] max_speed_ff, min_speed_ff;

   // regulator state
   logic [7:0]  pwm_count_ff, pwm_count_in;
   logic [15:0] measure_count_ff, measure_count_in;
   logic [15:0] adjust_count_ff, adjust_count_in;
   logic [15:0] key_count_ff, key_count_in;
   logic [15:0] led_count_ff, led_count_in;
   logic [15:0] lap_count_ff, lap_count_in;
   logic [15:0] measured_speed_ff, measured_speed_in;
   logic [9:0]  target_speed_ff, target_speed_in;
   logic [7:0]  duty_ff, duty_in;
   logic        drive_bit_ff, drive_bit_in;
   logic        led_level_ff, led_level_in;

   // pipeline
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff, skid_valid_ff;
   rsp_word_type out_word_ff, skid_word_ff, result_word;
   logic         process, pop;

   logic [15:0] measure_inc, adjust_inc, key_inc, led_inc, lap_inc;
   logic [8:0]  pwm_next;
   logic [8:0]  duty_step;
   logic [7:0]  duty_hi;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff    <= PWM_PERIOD_RESET;
         measure_ticks_ff <= MEASURE_TICKS_RESET;
         adjust_ticks_ff  <= ADJUST_TICKS_RESET;
         key_ticks_ff     <= KEY_TICKS_RESET;
         led_ticks_ff     <= LED_TICKS_RESET;
         max_speed_ff     <= MAX_SPEED_RESET;
         min_speed_ff     <= MIN_SPEED_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.data.index)
            CSR_PWM_PERIOD:    pwm_period_ff    <= csr_bus.data.value[7:0];
            CSR_MEASURE_TICKS: measure_ticks_ff <= csr_bus.data.value;
            CSR_ADJUST_TICKS:  adjust_ticks_ff  <= csr_bus.data.value;
            CSR_KEY_TICKS:     key_ticks_ff     <= csr_bus.data.value;
            CSR_LED_TICKS:     led_ticks_ff     <= csr_bus.data.value;
            CSR_MAX_SPEED:     max_speed_ff     <= csr_bus.data.value;
            CSR_MIN_SPEED:     min_speed_ff     <= csr_bus.data.value;
            // writes to the start speed are ignored; reset always restores the default start speed
            CSR_START_SET_SPEED: ;
            default: ;
         endcase
      end
   end

   // handshake
   assign pop           = out_valid_ff && rsp_bus.ready;
   assign process       = in_valid_ff && !skid_valid_ff;
   assign req_bus.ready = !in_valid_ff || process;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_word_ff;

   // one tick of the regulator
   always_comb begin
      measure_inc = tick_up(measure_count_ff);
      adjust_inc  = tick_up(adjust_count_ff);
      key_inc     = tick_up(key_count_ff);
      led_inc     = tick_up(led_count_ff);
      lap_inc     = in_word_ff.pulse ? tick_up(lap_count_ff) : lap_count_ff;

      // keys: down over up over stop
      key_count_in    = key_inc;
      target_speed_in = target_speed_ff;
      if (key_inc >= key_ticks_ff) begin
         key_count_in = 16'd0;
         if (in_word_ff.key_down) begin
            if (target_speed_ff != 10'd0) target_speed_in = target_speed_ff - 10'd1;
         end else if (in_word_ff.key_up) begin
            if (target_speed_ff != TARGET_MAX) target_speed_in = target_speed_ff + 10'd1;
         end else if (in_word_ff.key_stop) begin
            target_speed_in = 10'd0;
         end
      end

      // alarm LED looks at the speed from before this tick's measurement
      led_count_in = led_inc;
      led_level_in = led_level_ff;
      if (led_inc >= led_ticks_ff) begin
         led_count_in = 16'd0;
         if (measured_speed_ff > max_speed_ff || measured_speed_ff < min_speed_ff)
            led_level_in = !led_level_ff;
         else
            led_level_in = 1'b1;
      end

      // PWM: 9-bit count so a period of 255 still wraps
      pwm_next     = {1'b0, pwm_count_ff} + 9'd1;
      drive_bit_in = drive_bit_ff;
      if (pwm_next > {1'b0, pwm_period_ff}) begin
         pwm_count_in = 8'd0;
         drive_bit_in = 1'b1;
      end else begin
         pwm_count_in = pwm_next[7:0];
         if (pwm_next[7:0] == duty_ff) drive_bit_in = 1'b0;
      end

      // speed window
      measure_count_in  = measure_inc;
      measured_speed_in = measured_speed_ff;
      lap_count_in      = lap_inc;
      if (measure_inc >= measure_ticks_ff) begin
         measure_count_in  = 16'd0;
         measured_speed_in = lap_inc;
         lap_count_in      = 16'd0;
      end

      // duty step toward target, clamped to 1..period-1
      adjust_count_in = adjust_inc;
      duty_in         = duty_ff;
      duty_hi         = (pwm_period_ff >= 8'd2) ? pwm_period_ff - 8'd1 : 8'd1;
      duty_step       = {1'b0, duty_ff};
      if (adjust_inc >= adjust_ticks_ff) begin
         adjust_count_in = 16'd0;
         if ({6'd0, target_speed_in} != measured_speed_in) begin
            if ({6'd0, target_speed_in} > measured_speed_in)
               duty_step = {1'b0, duty_ff} + 9'd1;
            else
               duty_step = (duty_ff > 8'd1) ? {1'b0, duty_ff - 8'd1} : 9'd1;
            if (duty_step > {1'b0, duty_hi}) duty_step = {1'b0, duty_hi};
            if (duty_step == 9'd0) duty_step = 9'd1;
            duty_in = duty_step[7:0];
         end
      end

      result_word.motor_enable   = drive_bit_in;
      result_word.alarm_led      = led_level_in;
      result_word.duty_now       = duty_in;
      result_word.speed_measured = measured_speed_in;
      result_word.speed_target   = target_speed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff      <= 8'd0;
         measure_count_ff  <= 16'd0;
         adjust_count_ff   <= 16'd0;
         key_count_ff      <= 16'd0;
         led_count_ff      <= 16'd0;
         lap_count_ff      <= 16'd0;
         measured_speed_ff <= 16'd0;
         target_speed_ff   <= START_SPEED_RESET;
         duty_ff           <= DUTY_RESET;
         drive_bit_ff      <= 1'b1;
         led_level_ff      <= 1'b1;
      end else if (process) begin
         pwm_count_ff      <= pwm_count_in;
         measure_count_ff  <= measure_count_in;
         adjust_count_ff   <= adjust_count_in;
         key_count_ff      <= key_count_in;
         led_count_ff      <= led_count_in;
         lap_count_ff      <= lap_count_in;
         measured_speed_ff <= measured_speed_in;
         target_speed_ff   <= target_speed_in;
         duty_ff           <= duty_in;
         drive_bit_ff      <= drive_bit_in;
         led_level_ff      <= led_level_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_word_ff <= req_bus.data;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= process || skid_valid_ff || (out_valid_ff && !pop);
         if (skid_valid_ff) begin
            if (pop) skid_valid_ff <= 1'b0;
         end else if (process && out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_word_ff <= skid_word_ff;
      end else if (process) begin
         if (!out_valid_ff || pop) out_word_ff  <= result_word;
         else                      skid_word_ff <= result_word;
      end
   end

endmodule

// ===== sv/msr_checker.sv =====
module msr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input msr_pkg::rsp_word_type rsp_data
);
   import msr_pkg::*;

   // a result only appears for a word that was accepted earlier
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without accepted word");

   // every accepted word is followed by a valid result on the output
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid)
      else $error("accepted word did not reach output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.duty_now != 8'd0 && rsp_data.duty_now != 8'd255))
      else $error("duty outside 1..254");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind motor_speed_pwm_regulator_top msr_checker u_msr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
